[rtl/route_relocate_best_move_scan_core_macros.svh]
// Assertion macros for the relocate move scan core.
// Included by the top level; no other dependencies.
`ifndef ROUTE_RELOCATE_BEST_MOVE_SCAN_CORE_MACROS_SVH
`define ROUTE_RELOCATE_BEST_MOVE_SCAN_CORE_MACROS_SVH

// Implication checked every cycle outside reset.
`define RRBM_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("relocate scan check failed");

// Invariant checked every cycle outside reset.
`define RRBM_ASSERT_ALWAYS(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) \
    else $error("relocate scan invariant failed");

`endif

[rtl/rrbm_pkg.sv]
// Shared types and constants of the relocate move scan core.
// No dependencies.
package rrbm_pkg;

  localparam int MaxRoutes   = 32;
  localparam int MaxRouteLen = 64;
  localparam int DeltaW      = 20;

  localparam logic [28:0] W_SRC = 29'd10000019;
  localparam logic [28:0] W_POS = 29'd100003;
  localparam logic [28:0] W_DST = 29'd1009;

  localparam logic signed [DeltaW-1:0] BestFloor = -20'sd131072;

  typedef enum logic [2:0] {
    KIND_DIST   = 3'd0,
    KIND_SLOT   = 3'd1,
    KIND_LENGTH = 3'd2,
    KIND_DEMAND = 3'd3,
    KIND_LOAD   = 3'd4,
    KIND_START  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_DEPOT    = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_LIMIT    = 2'd2,
    REG_ROUTES   = 2'd3
  } reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SRC, S_POS, S_PS, S_NS, S_G1, S_G2, S_G3, S_G4,
    S_DST, S_INS, S_PT, S_NT, S_D1, S_D2, S_D3, S_ACC, S_DONE
  } state_t;

endpackage

[rtl/route_relocate_best_move_scan_core.sv]
// Relocate move scan core: loads routing tables and scans relocate moves.
// Depends on rrbm_pkg and route_relocate_best_move_scan_core_macros.svh.
//
//  - s_axis carries requests. tuser is the kind; tdata holds load fields.
//    Load requests write the tables one per cycle while idle and give no result.
//  - A start request launches the scan; s_axis_tready stays low until the
//    scan finishes and its result is registered on m_axis.
//  - The scan walks each scanned route (route_count, capped at 32), each
//    position, each feasible destination and each insertion point; a route
//    of n customers has n + 1 points. One registered port per table: each
//    move does two slot reads, three distance reads, difference, accumulate.
//  - The early-stop check runs before each move; the scan ends as soon as
//    the move count reaches check_limit.
//  - If m_axis_tready is low when a scan ends while the output register is
//    full, the sequencer waits in its done state; loads resume in idle.
//  - Reset (rst, synchronous) clears route lengths, route loads, the
//    registers (check_limit to all ones, route_count to 32) and the output.
//    Distance, slot and demand memories are not cleared.
//  - cfg_we/cfg_index/cfg_data write registers; write only while idle.
`include "route_relocate_best_move_scan_core_macros.svh"

module route_relocate_best_move_scan_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: from_node[7:0] to_node[15:8] distance[31:16] route_id[36:32]
  //        slot[42:37] customer[50:43] length[57:51] demand_node[65:58]
  //        demand_value[81:66] load_value[101:82], zero fill above
  input  logic [103:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: checks[31:0] min_delta[49:32] best_source[55:50]
  //        best_position[62:56] best_target[68:63] best_insert[76:69]
  //        delta_sum[140:77] index_sum[203:141], zero fill above
  output logic [207:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DW = rrbm_pkg::DeltaW;

  // request fields
  logic [7:0]  from_node, to_node, customer, demand_node;
  logic [15:0] distance, demand_value;
  logic [4:0]  route_id;
  logic [5:0]  slot;
  logic [6:0]  length;
  logic [19:0] load_value;
  assign from_node    = s_axis_tdata[7:0];
  assign to_node      = s_axis_tdata[15:8];
  assign distance     = s_axis_tdata[31:16];
  assign route_id     = s_axis_tdata[36:32];
  assign slot         = s_axis_tdata[42:37];
  assign customer     = s_axis_tdata[50:43];
  assign length       = s_axis_tdata[57:51];
  assign demand_node  = s_axis_tdata[65:58];
  assign demand_value = s_axis_tdata[81:66];
  assign load_value   = s_axis_tdata[101:82];

  // config registers
  logic [7:0]  depot_node;
  logic [19:0] capacity;
  logic [31:0] check_limit;
  logic [5:0]  route_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      depot_node  <= '0;
      capacity    <= '0;
      check_limit <= '1;
      route_count <= 6'd32;
    end else if (cfg_we) begin
      unique case (rrbm_pkg::reg_t'(cfg_index))
        rrbm_pkg::REG_DEPOT:    depot_node  <= cfg_data[7:0];
        rrbm_pkg::REG_CAPACITY: capacity    <= cfg_data[19:0];
        rrbm_pkg::REG_LIMIT:    check_limit <= cfg_data;
        rrbm_pkg::REG_ROUTES:   route_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  rrbm_pkg::state_t state, state_next;
  logic accept;
  assign s_axis_tready = (state == rrbm_pkg::S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // small tables in flops, cleared by reset
  logic [6:0]  route_len [rrbm_pkg::MaxRoutes];
  logic [19:0] route_load [rrbm_pkg::MaxRoutes];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrbm_pkg::MaxRoutes; i++) begin
        route_len[i]  <= '0;
        route_load[i] <= '0;
      end
    end else if (accept) begin
      if (s_axis_tuser == rrbm_pkg::KIND_LENGTH)
        route_len[route_id] <= (length > 7'(rrbm_pkg::MaxRouteLen)) ?
                               7'(rrbm_pkg::MaxRouteLen) : length;
      if (s_axis_tuser == rrbm_pkg::KIND_LOAD)
        route_load[route_id] <= load_value;
    end
  end

  // scan registers
  logic [5:0]  rc, src, dst;
  logic [6:0]  pos, slen, ins, dlen;
  logic [7:0]  node, ps, ns, pt, nt;
  logic [15:0] demand;
  logic signed [DW-1:0] acc, gain, delta, best;
  logic [31:0] checks;
  logic [63:0] dsum;
  logic [62:0] isum;
  logic [28:0] wsrc, wpos, wdst;
  logic [29:0] wbase;
  logic signed [5:0] bs, bd;
  logic signed [6:0] bp;
  logic signed [7:0] bi;
  logic out_valid;

  // memories
  logic [15:0] dist_mem [65536];
  logic [7:0]  slot_mem [2048];
  logic [15:0] dem_mem  [256];
  logic [15:0] dist_rdata, dem_rdata;
  logic [7:0]  slot_rdata;
  logic [15:0] dist_raddr;
  logic [10:0] slot_raddr;

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == rrbm_pkg::KIND_DIST)
      dist_mem[{from_node, to_node}] <= distance;
    dist_rdata <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == rrbm_pkg::KIND_SLOT)
      slot_mem[{route_id, slot}] <= customer;
    slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == rrbm_pkg::KIND_DEMAND)
      dem_mem[demand_node] <= demand_value;
    dem_rdata <= dem_mem[node];
  end

  // read address selection
  logic [6:0] pos_m1, pos_p1, ins_m1;
  assign pos_m1 = pos - 7'd1;
  assign pos_p1 = pos + 7'd1;
  assign ins_m1 = ins - 7'd1;

  always_comb begin
    slot_raddr = {src[4:0], pos[5:0]};
    dist_raddr = {ps, node};
    case (state)
      rrbm_pkg::S_PS:  slot_raddr = {src[4:0], pos_m1[5:0]};
      rrbm_pkg::S_NS:  slot_raddr = {src[4:0], pos_p1[5:0]};
      rrbm_pkg::S_INS: slot_raddr = {dst[4:0], ins_m1[5:0]};
      rrbm_pkg::S_PT:  slot_raddr = {dst[4:0], ins[5:0]};
      default: ;
    endcase
    case (state)
      rrbm_pkg::S_G2: dist_raddr = {node, ns};
      rrbm_pkg::S_G3: dist_raddr = {ps, ns};
      rrbm_pkg::S_NT: dist_raddr = {pt, node};
      rrbm_pkg::S_D1: dist_raddr = {node, nt};
      rrbm_pkg::S_D2: dist_raddr = {pt, nt};
      default: ;
    endcase
  end

  // destination feasibility
  logic [20:0] dst_need;
  logic dst_skip;
  assign dst_need = {1'b0, route_load[dst[4:0]]} + {5'd0, demand};
  assign dst_skip = (dst == src) || (dst_need > {1'b0, capacity});

  logic signed [DW-1:0] dist_s;
  assign dist_s = DW'(signed'({1'b0, dist_rdata}));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrbm_pkg::S_IDLE:
        if (accept && s_axis_tuser == rrbm_pkg::KIND_START) state_next = rrbm_pkg::S_SRC;
      rrbm_pkg::S_SRC: state_next = (src < rc) ? rrbm_pkg::S_POS : rrbm_pkg::S_DONE;
      rrbm_pkg::S_POS: state_next = (pos < slen) ? rrbm_pkg::S_PS : rrbm_pkg::S_SRC;
      rrbm_pkg::S_PS:  state_next = rrbm_pkg::S_NS;
      rrbm_pkg::S_NS:  state_next = rrbm_pkg::S_G1;
      rrbm_pkg::S_G1:  state_next = rrbm_pkg::S_G2;
      rrbm_pkg::S_G2:  state_next = rrbm_pkg::S_G3;
      rrbm_pkg::S_G3:  state_next = rrbm_pkg::S_G4;
      rrbm_pkg::S_G4:  state_next = rrbm_pkg::S_DST;
      rrbm_pkg::S_DST:
        if (dst >= rc) state_next = rrbm_pkg::S_POS;
        else if (!dst_skip) state_next = rrbm_pkg::S_INS;
      rrbm_pkg::S_INS:
        if (ins > dlen) state_next = rrbm_pkg::S_DST;
        else if (checks >= check_limit) state_next = rrbm_pkg::S_DONE;
        else state_next = rrbm_pkg::S_PT;
      rrbm_pkg::S_PT:  state_next = rrbm_pkg::S_NT;
      rrbm_pkg::S_NT:  state_next = rrbm_pkg::S_D1;
      rrbm_pkg::S_D1:  state_next = rrbm_pkg::S_D2;
      rrbm_pkg::S_D2:  state_next = rrbm_pkg::S_D3;
      rrbm_pkg::S_D3:  state_next = rrbm_pkg::S_ACC;
      rrbm_pkg::S_ACC: state_next = rrbm_pkg::S_INS;
      rrbm_pkg::S_DONE:
        if (!out_valid || m_axis_tready) state_next = rrbm_pkg::S_IDLE;
      default: state_next = rrbm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rrbm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      rrbm_pkg::S_IDLE: begin
        rc     <= (route_count > 6'(rrbm_pkg::MaxRoutes)) ?
                  6'(rrbm_pkg::MaxRoutes) : route_count;
        src    <= '0;
        wsrc   <= rrbm_pkg::W_SRC;
        checks <= '0;
        dsum   <= '0;
        isum   <= '0;
        best   <= '0;
        bs <= -6'sd1; bp <= -7'sd1; bd <= -6'sd1; bi <= -8'sd1;
      end
      rrbm_pkg::S_SRC: begin
        slen <= route_len[src[4:0]];
        pos  <= '0;
        wpos <= rrbm_pkg::W_POS;
      end
      rrbm_pkg::S_POS:
        if (pos >= slen) begin
          src  <= src + 6'd1;
          wsrc <= wsrc + rrbm_pkg::W_SRC;
        end
      rrbm_pkg::S_PS: node <= slot_rdata;
      rrbm_pkg::S_NS: ps <= (pos == 7'd0) ? depot_node : slot_rdata;
      rrbm_pkg::S_G1: begin
        ns     <= (pos == slen - 7'd1) ? depot_node : slot_rdata;
        demand <= dem_rdata;
      end
      rrbm_pkg::S_G2: acc <= dist_s;
      rrbm_pkg::S_G3: acc <= acc + dist_s;
      rrbm_pkg::S_G4: begin
        gain <= acc - dist_s;
        dst  <= '0;
        wdst <= rrbm_pkg::W_DST;
      end
      rrbm_pkg::S_DST:
        if (dst >= rc) begin
          pos  <= pos + 7'd1;
          wpos <= wpos + rrbm_pkg::W_POS;
        end else if (dst_skip) begin
          dst  <= dst + 6'd1;
          wdst <= wdst + rrbm_pkg::W_DST;
        end else begin
          dlen  <= route_len[dst[4:0]];
          ins   <= '0;
          wbase <= {1'b0, wsrc} + {1'b0, wpos} + {1'b0, wdst};
        end
      rrbm_pkg::S_INS:
        if (ins > dlen) begin
          dst  <= dst + 6'd1;
          wdst <= wdst + rrbm_pkg::W_DST;
        end
      rrbm_pkg::S_PT: pt <= (ins == 7'd0) ? depot_node : slot_rdata;
      rrbm_pkg::S_NT: nt <= (ins == dlen) ? depot_node : slot_rdata;
      rrbm_pkg::S_D1: acc <= dist_s;
      rrbm_pkg::S_D2: acc <= acc + dist_s;
      rrbm_pkg::S_D3: delta <= acc - dist_s - gain;
      rrbm_pkg::S_ACC: begin
        checks <= checks + 32'd1;
        dsum   <= dsum + 64'(delta);
        isum   <= isum + 63'(wbase) + 63'(ins);
        ins    <= ins + 7'd1;
        if (delta < best) begin
          best <= delta;
          bs <= signed'(src);
          bp <= signed'(pos);
          bd <= signed'(dst);
          bi <= signed'({1'b0, ins});
        end
      end
      default: ;
    endcase
  end

  // output register
  logic signed [DW-1:0] best_sat;
  assign best_sat = (best < rrbm_pkg::BestFloor) ? rrbm_pkg::BestFloor : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rrbm_pkg::S_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rrbm_pkg::S_DONE && (!out_valid || m_axis_tready))
      m_axis_tdata <= {4'd0, isum, dsum, bi, bd, bp, bs, best_sat[17:0], checks};
  end

  assign m_axis_tvalid = out_valid;

  `RRBM_ASSERT_IMPLY(a_eval_under_limit, clk, rst, state == rrbm_pkg::S_ACC, checks < check_limit)
  `RRBM_ASSERT_ALWAYS(a_best_nonpositive, clk, rst, best <= 0)
  `RRBM_ASSERT_IMPLY(a_none_means_zero, clk, rst, state == rrbm_pkg::S_DONE && bs == -6'sd1, best == 0)
  `RRBM_ASSERT_IMPLY(a_busy_blocks_input, clk, rst, state != rrbm_pkg::S_IDLE, !s_axis_tready)

endmodule
